// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is held.
`define KCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define KCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kce_pkg.sv =====
// Shared constants and types of the k-combination enumerator.
package kce_pkg;

  localparam int MAX_N = 64;
  localparam int MAX_K = 16;

  localparam int VAL_W = 7;
  localparam int POS_W = 4;
  localparam int N_W   = 7;
  localparam int K_W   = 5;
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_N_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_K_SIZE  = CFG_IDX_W'(1);

  localparam logic [N_W-1:0] N_RESET = N_W'(4);
  localparam logic [K_W-1:0] K_RESET = K_W'(2);

  // one element waiting between memory access and the output register
  typedef struct packed {
    logic             use_new;
    logic [VAL_W-1:0] nv;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             exh;
    logic             empty;
  } elem_t;

endpackage

// ===== hdl/k_combination_enumerator.sv =====
// A restart request goes from IDLE to EMIT (to SINGLE when k is 0 or too large); each
// element passes through a_r and then the b_r output register. A next request scans the
// stored combination from position k-1 downward, one read per cycle over the single RAM
// port, then streams k elements one per cycle while out_stall does not hold them.
// Reset clears the control state and the config to n=4, k=2; the RAM is not cleared.
module k_combination_enumerator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kce_pkg::VAL_W-1:0]     out_value,
  output logic [kce_pkg::POS_W-1:0]     out_position,
  output logic                          out_last,
  output logic                          out_exhausted,
  output logic                          out_empty_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kce_pkg::CFG_DAT_W-1:0] cfg_data
);
  import kce_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;
  localparam logic [1:0] ST_SINGLE = 2'd3;

  localparam logic [N_W-1:0] N_SAT   = N_W'(MAX_N);
  localparam logic [K_W:0]   K_LIMIT = (K_W+1)'(MAX_K);

  logic [1:0]       state_r, state_nxt;
  logic [N_W-1:0]   n_count_r;
  logic [K_W-1:0]   k_size_r;
  logic             started_r, finished_r;

  logic [IDX_W-1:0] scan_idx_r;
  logic             scan_left_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [IDX_W-1:0] p_r;
  logic [IDX_W-1:0] e_r;
  logic [VAL_W-1:0] nv_r;
  logic             sng_exh_r, sng_empty_r;

  elem_t            a_r;
  logic             a_vld_r;
  logic             out_valid_r;
  elem_t            b_r;

  logic [VAL_W-1:0] mem [MAX_K];
  logic [VAL_W-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [VAL_W-1:0] mem_wd;

  logic [N_W-1:0]   n_eff;
  logic             k_bad;
  logic             in_acc;
  logic             a_to_b, a_free, issue;
  logic [IDX_W-1:0] k_last;
  logic [N_W:0]     ceil_v;
  logic             grow;
  elem_t            a_nxt;

  assign n_eff  = (n_count_r > N_SAT) ? N_SAT : n_count_r;
  assign k_bad  = ({1'b0, k_size_r} > K_LIMIT) || ({2'b0, k_size_r} > n_eff);
  assign k_last = IDX_W'(k_size_r - K_W'(1));

  assign in_stall  = (state_r != ST_IDLE) || a_vld_r;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign a_to_b = a_vld_r && (!out_valid_r || !out_stall);
  assign a_free = !a_vld_r || a_to_b;
  assign issue  = a_free && ((state_r == ST_EMIT) || (state_r == ST_SINGLE));

  // ceiling of a position: n - k + 1 + p
  assign ceil_v = {1'b0, n_eff} - (N_W+1)'(k_size_r) + (N_W+1)'(1) + (N_W+1)'(cmp_idx_r);
  assign grow   = {1'b0, rd_data_r} < ceil_v;

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = scan_idx_r;
    mem_wd   = nv_r;
    a_nxt    = '0;
    unique case (state_r)
      ST_SCAN: begin
        mem_re = scan_left_r;
      end
      ST_EMIT: begin
        mem_addr      = e_r;
        a_nxt.use_new = (e_r >= p_r);
        a_nxt.nv      = nv_r;
        a_nxt.pos     = POS_W'(e_r);
        a_nxt.last    = (e_r == k_last);
        if (issue) begin
          mem_we = (e_r >= p_r);
          mem_re = (e_r < p_r);
        end
      end
      ST_SINGLE: begin
        a_nxt.use_new = 1'b1;
        a_nxt.last    = 1'b1;
        a_nxt.exh     = sng_exh_r;
        a_nxt.empty   = sng_empty_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_restart || !started_r) begin
            state_nxt = (k_bad || k_size_r == '0) ? ST_SINGLE : ST_EMIT;
          end else if (finished_r || k_size_r == '0 || k_bad) begin
            state_nxt = ST_SINGLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && grow) state_nxt = ST_EMIT;
        else if (cmp_vld_r && cmp_idx_r == '0) state_nxt = ST_SINGLE;
      end
      ST_EMIT: begin
        if (issue && a_nxt.last) state_nxt = ST_IDLE;
      end
      ST_SINGLE: begin
        if (issue) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_count_r   <= N_RESET;
      k_size_r    <= K_RESET;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      scan_left_r <= 1'b0;
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_N_COUNT) begin
          n_count_r <= N_W'(cfg_data);
          started_r <= 1'b0;
        end else if (cfg_index == REG_K_SIZE) begin
          k_size_r  <= cfg_data[K_W-1:0];
          started_r <= 1'b0;
        end
      end

      if (state_r == ST_IDLE && in_acc) begin
        if (in_restart || !started_r) begin
          started_r  <= 1'b1;
          finished_r <= k_bad || (k_size_r == '0);
        end else if (finished_r || k_size_r == '0 || k_bad) begin
          finished_r <= 1'b1;
        end
      end
      if (state_r == ST_SCAN && cmp_vld_r && !grow && cmp_idx_r == '0) begin
        finished_r <= 1'b1;
      end

      // scan read pipeline: address issued now, compared next cycle
      if (state_r == ST_IDLE) begin
        scan_left_r <= 1'b1;
        cmp_vld_r   <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        cmp_vld_r <= scan_left_r;
        if (scan_left_r && scan_idx_r == '0) scan_left_r <= 1'b0;
      end else begin
        cmp_vld_r <= 1'b0;
      end

      if (a_to_b) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (issue) a_vld_r <= 1'b1;
      else if (a_to_b) a_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      scan_idx_r <= k_last;
      e_r        <= '0;
      p_r        <= '0;
      nv_r       <= VAL_W'(1);
      if ((in_restart || !started_r) && !k_bad && k_size_r == '0) begin
        sng_exh_r   <= 1'b0;
        sng_empty_r <= 1'b1;
      end else begin
        sng_exh_r   <= 1'b1;
        sng_empty_r <= 1'b0;
      end
    end
    if (state_r == ST_SCAN) begin
      if (scan_left_r) scan_idx_r <= scan_idx_r - IDX_W'(1);
      cmp_idx_r <= scan_idx_r;
      if (cmp_vld_r && grow) begin
        p_r  <= cmp_idx_r;
        nv_r <= rd_data_r + VAL_W'(1);
      end
    end
    if (state_r == ST_EMIT && issue) begin
      e_r <= e_r + IDX_W'(1);
      if (e_r >= p_r) nv_r <= nv_r + VAL_W'(1);
    end
    if (issue) a_r <= a_nxt;
    if (a_to_b) begin
      b_r <= {a_r.use_new, (a_r.use_new ? a_r.nv : rd_data_r), a_r.pos, a_r.last,
              a_r.exh, a_r.empty};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = b_r.nv;
  assign out_position  = b_r.pos;
  assign out_last      = b_r.last;
  assign out_exhausted = b_r.exh;
  assign out_empty_res = b_r.empty;

endmodule

// ===== hdl/kce_checker.sv =====
// Port-level checker for the k-combination enumerator and its bind.
`include "assert_macros.svh"

module kce_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_restart,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kce_pkg::VAL_W-1:0]     out_value,
  input logic [kce_pkg::POS_W-1:0]     out_position,
  input logic                          out_last,
  input logic                          out_exhausted,
  input logic                          out_empty_res,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [kce_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [kce_pkg::CFG_DAT_W-1:0] cfg_data
);
  import kce_pkg::*;

  logic unused_in;
  assign unused_in = ^{in_valid, in_stall, in_restart, out_stall, cfg_valid, cfg_ready,
                       cfg_index, cfg_data};

  // an exhausted beat ends its request and carries no element
  `KCE_ASSERT(a_exh_shape, clk, rst_n, out_valid && out_exhausted |-> out_last && out_value == '0 && out_position == '0 && !out_empty_res, "exhausted beat malformed")
  // the empty combination is a single zero beat
  `KCE_ASSERT(a_empty_shape, clk, rst_n, out_valid && out_empty_res |-> out_last && out_value == '0 && out_position == '0 && !out_exhausted, "empty beat malformed")
  // real elements are never zero
  `KCE_ASSERT(a_elem_nonzero, clk, rst_n, out_valid && !out_exhausted && !out_empty_res |-> out_value != '0, "element value zero")
  // nothing on the result side right out of reset
  `KCE_ASSERT_ALWAYS(a_reset_quiet, clk, !$past(rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind k_combination_enumerator kce_checker u_kce_checker (.*);
